### rtl/core/rbd_pkg.sv
// Shared types and constants of the run-length byte decoder.
// Depends on nothing; used by rbd_front, rbd_queue, rbd_back and the top level.
package rbd_pkg;

	localparam int ADDR_WIDTH  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// buffer offsets wrap at 2^ADDR_WIDTH
	localparam logic [15:0] ADDR_MASK = 16'((17'd1 << ADDR_WIDTH) - 17'd1);

	localparam logic [7:0] FILL_ONES  = 8'hff;
	localparam logic [7:0] FILL_ZEROS = 8'h00;
	localparam logic [4:0] LEN_MASK   = 5'h1f;

	// register indexes of the configuration port
	localparam logic REG_TOTAL_BYTES = 1'b0;
	localparam logic REG_MIRROR_MODE = 1'b1;

	// one span of equal bytes, ready for the back end to play out
	typedef struct packed {
		logic [7:0]  value;
		logic [15:0] start_pos;
		logic [5:0]  len;        // 1..32 bytes
		logic [16:0] cused;
	} span_t;

endpackage

### rtl/core/rbd_front.sv
// Front end: takes compressed words, tracks the decode phase and stream counters,
// and turns each word that yields output into a span for the queue. Uses rbd_pkg.
module rbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic [15:0]       total_bytes,
	output logic              push,
	output rbd_pkg::span_t    span
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_VALUE   = 2'd1;
	localparam logic [1:0] PH_LITERAL = 2'd2;
	localparam logic [16:0] COUNT_MAX = 17'h1ffff;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  lit_q, lit_d;
	logic [5:0]  run_q, run_d;
	logic [15:0] pos_q, pos_d;
	logic [16:0] cnt_q, cnt_d;

	logic        has_emit;
	logic [5:0]  emit_len;
	logic [7:0]  emit_val;
	logic [16:0] cnt_inc;
	logic [16:0] pos17, tot17, rem, len17;
	logic        first_done, done;
	logic [5:0]  n_emit;
	logic        live;

	assign live = accept && (total_bytes != 16'd0);

	always_comb begin
		phase_d  = phase_q;
		lit_d    = lit_q;
		run_d    = run_q;
		has_emit = 1'b0;
		emit_len = 6'd1;
		emit_val = data_byte;
		cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 17'd1;
		case (phase_q)
			PH_VALUE: begin
				has_emit = 1'b1;
				emit_len = run_q;
				phase_d  = PH_HEADER;
				run_d    = 6'd0;
			end
			PH_LITERAL: begin
				has_emit = 1'b1;
				lit_d    = lit_q - 8'd1;
				if (lit_d == 8'd0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (data_byte[7]) begin
					if (data_byte[6] || data_byte[5]) begin
						has_emit = 1'b1;
						emit_len = {1'b0, data_byte[4:0] & rbd_pkg::LEN_MASK} + 6'd1;
						emit_val = data_byte[6] ? rbd_pkg::FILL_ONES : rbd_pkg::FILL_ZEROS;
					end else begin
						run_d   = {1'b0, data_byte[4:0] & rbd_pkg::LEN_MASK} + 6'd1;
						phase_d = PH_VALUE;
					end
				end else begin
					lit_d   = {1'b0, data_byte[6:0]} + 8'd1;
					phase_d = PH_LITERAL;
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase

		// how far this span gets before the stream completes
		pos17      = {1'b0, pos_q};
		tot17      = {1'b0, total_bytes};
		len17      = {11'd0, emit_len};
		first_done = (pos17 + 17'd1) >= tot17;
		rem        = tot17 - pos17;
		if (first_done) begin
			n_emit = 6'd1;
		end else if (len17 < rem) begin
			n_emit = emit_len;
		end else begin
			n_emit = rem[5:0];
		end
		done  = has_emit && (first_done || (len17 >= rem));
		pos_d = has_emit ? pos_q + {10'd0, n_emit} : pos_q;
		cnt_d = cnt_inc;

		// stream complete: rearm
		if (done) begin
			phase_d = PH_HEADER;
			lit_d   = 8'd0;
			run_d   = 6'd0;
			pos_d   = 16'd0;
			cnt_d   = 17'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lit_q   <= 8'd0;
			run_q   <= 6'd0;
			pos_q   <= 16'd0;
			cnt_q   <= 17'd0;
		end else if (live) begin
			phase_q <= phase_d;
			lit_q   <= lit_d;
			run_q   <= run_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
		end
	end

	assign push           = live && has_emit;
	assign span.value     = emit_val;
	assign span.start_pos = pos_q;
	assign span.len       = n_emit;
	assign span.cused     = cnt_inc;

endmodule

### rtl/core/rbd_queue.sv
// Short span queue between the front and back ends.
// Uses rbd_pkg for the span type and depth.
module rbd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rbd_pkg::span_t    push_span,
	input  logic              pop,
	output logic              head_valid,
	output rbd_pkg::span_t    head_span,
	output logic              full
);

	rbd_pkg::span_t                  mem_q [rbd_pkg::QUEUE_DEPTH];
	logic [rbd_pkg::PTR_W-1:0]       wr_q, rd_q;
	logic [rbd_pkg::CNT_W-1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_span;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == rbd_pkg::PTR_W'(rbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == rbd_pkg::PTR_W'(rbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head_span  = mem_q[rd_q];
	assign full       = (cnt_q == rbd_pkg::CNT_W'(rbd_pkg::QUEUE_DEPTH));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("span pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("span popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rbd_pkg::CNT_W'(rbd_pkg::QUEUE_DEPTH))
		else $error("queue fill count out of range");

endmodule

### rtl/core/rbd_back.sv
// Back end: plays each span out one word per cycle while the output is not stalled,
// into the output register, forming buffer address and last flag. Uses rbd_pkg.
module rbd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       total_bytes,
	input  logic              mirror_mode,
	input  logic              head_valid,
	input  rbd_pkg::span_t    head_span,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic [15:0]       out_addr,
	output logic              last,
	output logic [16:0]       compressed_used
);

	logic           active_q;
	rbd_pkg::span_t cur_q;
	rbd_pkg::span_t cur;
	logic           adv, emit;
	logic [15:0]    addr;
	logic           done;

	assign adv  = !out_valid || !out_stall;
	assign cur  = active_q ? cur_q : head_span;
	assign emit = adv && (active_q || head_valid);
	assign pop  = adv && !active_q && head_valid;

	always_comb begin
		if (mirror_mode) begin
			addr = (total_bytes - 16'd1 - cur.start_pos) & rbd_pkg::ADDR_MASK;
		end else begin
			addr = cur.start_pos & rbd_pkg::ADDR_MASK;
		end
		done = ({1'b0, cur.start_pos} + 17'd1) >= {1'b0, total_bytes};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				out_valid <= emit;
			end
			if (emit) begin
				active_q <= (cur.len > 6'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cur_q.value     <= cur.value;
			cur_q.start_pos <= cur.start_pos + 16'd1;
			cur_q.len       <= cur.len - 6'd1;
			cur_q.cused     <= cur.cused;
			out_byte        <= cur.value;
			out_addr        <= addr;
			last            <= done;
			compressed_used <= cur.cused;
		end
	end

	a_active_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cur_q.len != 6'd0))
		else $error("active span with no bytes left");

	a_last_ends_span: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && done) |=> !active_q)
		else $error("span continues past the last word of the stream");

	a_no_pop_while_active: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !pop)
		else $error("queue popped while a span is still playing");

endmodule

### rtl/core/rle_byte_decompressor_top.sv
// Top level of the run-length byte decoder with literal runs.
// Depends on rbd_pkg, rbd_front, rbd_queue and rbd_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   input   | in        | in_valid / in_stall   | data_byte[7:0]
//   output  | out       | out_valid / out_stall | out_byte, out_addr, last, compressed_used
//   config  | in        | cfg_we                | cfg_index (0 total_bytes, 1 mirror_mode),
//           |           |                       | cfg_data[15:0]
//
// Header and literal words are taken one per cycle while the input is not stalled; a run of N
// copies (N up to 32) leaves the back end one decoded word per cycle while the output is not stalled.
// The input stalls only while the two-entry span queue is full.
// Reset clears the decode phase, counters, queue and output valid; config goes to zero.
// The output register can take a new word in the same cycle the old one leaves.
module rle_byte_decompressor_top (
	input  logic        clk,
	input  logic        arst_n,
	// compressed input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// decoded output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] out_addr,
	output logic        last,
	output logic [16:0] compressed_used,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]    total_bytes_q;
	logic           mirror_mode_q;

	logic           in_accept;
	logic           push, pop;
	logic           head_valid, full;
	rbd_pkg::span_t push_span, head_span;

	// configuration registers; write only while the decoder is idle; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_bytes_q <= 16'd0;
			mirror_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rbd_pkg::REG_TOTAL_BYTES: total_bytes_q <= cfg_data;
				rbd_pkg::REG_MIRROR_MODE: mirror_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hold the input while the queue has no room for a span
	assign in_stall  = full;
	assign in_accept = in_valid && !in_stall;

	rbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.data_byte   (data_byte),
		.total_bytes (total_bytes_q),
		.push        (push),
		.span        (push_span)
	);

	rbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_span  (push_span),
		.pop        (pop),
		.head_valid (head_valid),
		.head_span  (head_span),
		.full       (full)
	);

	rbd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.total_bytes     (total_bytes_q),
		.mirror_mode     (mirror_mode_q),
		.head_valid      (head_valid),
		.head_span       (head_span),
		.pop             (pop),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.out_byte        (out_byte),
		.out_addr        (out_addr),
		.last            (last),
		.compressed_used (compressed_used)
	);

endmodule
